FILE: design/cpr_pkg.sv
`default_nettype none

package cpr_pkg;

  localparam logic OP_ACCESS  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] OUT_HIT      = 2'd0;
  localparam logic [1:0] OUT_FREE     = 2'd1;
  localparam logic [1:0] OUT_REPLACE  = 2'd2;
  localparam logic [1:0] OUT_RELEASED = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch;
    logic clr_step;
    logic rel_all;
    logic rd_lookup;
    logic hit_set;
    logic miss_init;
    logic scan_step;
    logic sweep_step;
    logic sweep_pick;
    logic inval_step;
    logic commit;
    logic emit;
  } cpr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_pid_ok;
    logic in_release;
    logic clr_last;
    logic hit;
    logic scan_free;
    logic scan_last;
    logic hand_visited;
    logic inval_done;
    logic out_free;
  } cpr_status_t;

endpackage

`default_nettype wire

FILE: design/cpr_ram.sv
`default_nettype none

module cpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/cpr_controller.sv
`default_nettype none

module cpr_controller (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cpr_pkg::cpr_status_t status,
  output cpr_pkg::cpr_cmd_t         cmd
);

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_RELEASE = 4'd2;
  localparam logic [3:0] ST_LOOKUP  = 4'd3;
  localparam logic [3:0] ST_CHECK   = 4'd4;
  localparam logic [3:0] ST_SCAN    = 4'd5;
  localparam logic [3:0] ST_SWEEP   = 4'd6;
  localparam logic [3:0] ST_INVAL   = 4'd7;
  localparam logic [3:0] ST_COMMIT  = 4'd8;
  localparam logic [3:0] ST_DONE    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          // a beat with an unknown process leaves no trace
          if (!status.in_pid_ok) state_next = ST_IDLE;
          else if (status.in_release) state_next = ST_RELEASE;
          else state_next = ST_LOOKUP;
        end
      end
      ST_RELEASE: begin
        cmd.rel_all = 1'b1;
        state_next  = ST_DONE;
      end
      ST_LOOKUP: begin
        cmd.rd_lookup = 1'b1;
        state_next    = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.hit) begin
          cmd.hit_set = 1'b1;
          state_next  = ST_DONE;
        end else begin
          cmd.miss_init = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_free) state_next = ST_INVAL;
        else if (status.scan_last) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (status.hand_visited) begin
          cmd.sweep_step = 1'b1;
        end else begin
          cmd.sweep_pick = 1'b1;
          state_next     = ST_INVAL;
        end
      end
      ST_INVAL: begin
        cmd.inval_step = 1'b1;
        if (status.inval_done) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/cpr_datapath.sv
`default_nettype none

module cpr_datapath #(
  parameter int FRAMES            = 4,
  parameter int PAGES_PER_PROCESS = 32,
  parameter int PROCESSES         = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cpr_pkg::cpr_cmd_t cmd,
  output cpr_pkg::cpr_status_t   status,
  input  wire logic              op,
  input  wire logic [2:0]        process_id,
  input  wire logic [4:0]        virtual_page,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             outcome,
  output logic [1:0]             frame,
  output logic                   same_process_evicted
);

  localparam int FW    = $clog2(FRAMES);
  localparam int DEPTH = PROCESSES * PAGES_PER_PROCESS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(PAGES_PER_PROCESS);
  localparam int CW    = $clog2(PAGES_PER_PROCESS + 1);
  localparam int WW    = FW + 1;

  // page number folded into the table range
  logic [PW-1:0] vp_mod_tab [32];
  for (genvar g = 0; g < 32; g++) begin : g_vp_mod
    assign vp_mod_tab[g] = PW'(g % PAGES_PER_PROCESS);
  end

  logic [2:0]    pid_r;
  logic [AW-1:0] base;
  logic [AW-1:0] idx;
  logic [AW-1:0] base_in;

  logic          owned   [FRAMES];
  logic [2:0]    owner   [FRAMES];
  logic          visited [FRAMES];
  logic [FW-1:0] hand;
  logic [FW-1:0] scan_cnt;
  logic [FW-1:0] chosen;
  logic          replaced;

  logic [1:0]    res_outcome;
  logic [FW-1:0] res_frame;
  logic          res_same;
  logic [FW+1:0] res_frame_ext;

  logic [AW-1:0] clr_cnt;
  logic [CW-1:0] inval_cnt;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic          inval_issue;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;
  logic          rd_valid;
  logic [FW-1:0] rd_frame;

  assign rd_valid = ram_rdata[WW-1];
  assign rd_frame = ram_rdata[FW-1:0];

  assign base_in     = AW'((32'(process_id) - 32'd1) * PAGES_PER_PROCESS);
  assign inval_issue = (32'(inval_cnt) < PAGES_PER_PROCESS);

  cpr_ram #(
    .WIDTH(WW),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = idx;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
    end else if (cmd.commit) begin
      ram_we    = 1'b1;
      ram_wdata = {1'b1, chosen};
    end else if (cmd.inval_step && pend && rd_frame == chosen) begin
      // drop any entry of this process that still names the chosen frame
      ram_we    = 1'b1;
      ram_waddr = pend_addr;
      ram_wdata = {1'b0, rd_frame};
    end
    if (cmd.rd_lookup) begin
      ram_re = 1'b1;
    end else if (cmd.inval_step && inval_issue) begin
      ram_re    = 1'b1;
      ram_raddr = base + AW'(inval_cnt);
    end
  end

  always_comb begin
    status.in_pid_ok    = (process_id != 3'd0) && (32'(process_id) <= PROCESSES);
    status.in_release   = (op == cpr_pkg::OP_RELEASE);
    status.clr_last     = (clr_cnt == AW'(DEPTH - 1));
    status.hit          = rd_valid && owned[rd_frame] && (owner[rd_frame] == pid_r);
    status.scan_free    = !owned[scan_cnt];
    status.scan_last    = (scan_cnt == FW'(FRAMES - 1));
    status.hand_visited = visited[hand];
    status.inval_done   = !inval_issue && !pend;
    status.out_free     = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pid_r <= process_id;
      base  <= base_in;
      idx   <= base_in + AW'(vp_mod_tab[virtual_page]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < FRAMES; f++) begin
        owned[f]   <= 1'b0;
        owner[f]   <= 3'd0;
        visited[f] <= 1'b0;
      end
      hand <= '0;
    end else begin
      if (cmd.rel_all) begin
        for (int f = 0; f < FRAMES; f++) begin
          if (owned[f] && owner[f] == pid_r) begin
            owned[f] <= 1'b0;
            owner[f] <= 3'd0;
          end
        end
      end
      if (cmd.hit_set) begin
        visited[rd_frame] <= 1'b1;
      end
      if (cmd.sweep_step) begin
        visited[hand] <= 1'b0;
        hand <= (hand == FW'(FRAMES - 1)) ? '0 : hand + 1'b1;
      end
      if (cmd.commit) begin
        owned[chosen]   <= 1'b1;
        owner[chosen]   <= pid_r;
        visited[chosen] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt  <= '0;
      inval_cnt <= '0;
      pend      <= 1'b0;
    end else begin
      if (cmd.miss_init) begin
        scan_cnt  <= '0;
        inval_cnt <= '0;
        pend      <= 1'b0;
      end
      if (cmd.scan_step) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (cmd.inval_step) begin
        pend <= inval_issue;
        if (inval_issue) begin
          pend_addr <= base + AW'(inval_cnt);
          inval_cnt <= inval_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && !owned[scan_cnt]) begin
      chosen   <= scan_cnt;
      replaced <= 1'b0;
      res_same <= 1'b0;
    end
    if (cmd.sweep_pick) begin
      chosen   <= hand;
      replaced <= 1'b1;
      res_same <= (owner[hand] == pid_r);
    end
    if (cmd.rel_all) begin
      res_outcome <= cpr_pkg::OUT_RELEASED;
      res_frame   <= '0;
      res_same    <= 1'b0;
    end
    if (cmd.hit_set) begin
      res_outcome <= cpr_pkg::OUT_HIT;
      res_frame   <= rd_frame;
      res_same    <= 1'b0;
    end
    if (cmd.commit) begin
      res_outcome <= replaced ? cpr_pkg::OUT_REPLACE : cpr_pkg::OUT_FREE;
      res_frame   <= chosen;
    end
  end

  assign res_frame_ext = (FW + 2)'(res_frame);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      outcome              <= res_outcome;
      frame                <= res_frame_ext[1:0];
      same_process_evicted <= res_same;
    end
  end

endmodule

`default_nettype wire

FILE: design/clock_page_replacement.sv
`default_nettype none

// Second-chance page replacement over PROCESSES page tables of PAGES_PER_PROCESS
// entries and FRAMES physical frames, one item at a time. After reset the page table
// memory is cleared one entry a cycle, all PROCESSES*PAGES_PER_PROCESS entries,
// before the first item is taken. A fault runs the free-frame scan, then the clock
// sweep when no frame is free, then walks the process's page table through the
// single memory read port to drop stale entries. A process id of 0 or above
// PROCESSES is taken and dropped with no result. The result sits in an output
// register, so the next item is taken while the previous one is still waiting.
module clock_page_replacement #(
  parameter int FRAMES            = 4,
  parameter int PAGES_PER_PROCESS = 32,
  parameter int PROCESSES         = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       op,
  input  wire logic [2:0] process_id,
  input  wire logic [4:0] virtual_page,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      outcome,
  output logic [1:0]      frame,
  output logic            same_process_evicted
);

  cpr_pkg::cpr_cmd_t    cmd;
  cpr_pkg::cpr_status_t status;

  cpr_controller u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  cpr_datapath #(
    .FRAMES           (FRAMES),
    .PAGES_PER_PROCESS(PAGES_PER_PROCESS),
    .PROCESSES        (PROCESSES)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .op                  (op),
    .process_id          (process_id),
    .virtual_page        (virtual_page),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .outcome             (outcome),
    .frame               (frame),
    .same_process_evicted(same_process_evicted)
  );

endmodule

`default_nettype wire

FILE: design/cpr_checker.sv
`default_nettype none

module cpr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       op,
  input wire logic [2:0] process_id,
  input wire logic [4:0] virtual_page,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] outcome,
  input wire logic [1:0] frame,
  input wire logic       same_process_evicted
);

  // an offered input beat holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(op) && $stable(process_id)
      && $stable(virtual_page))
    else $error("input beat changed while waiting");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(frame)
      && $stable(same_process_evicted))
    else $error("result beat changed while stalled");

  a_release_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == cpr_pkg::OUT_RELEASED |-> frame == 2'd0 && !same_process_evicted)
    else $error("release result carries a frame or eviction flag");

  a_same_only_replace: assert property (@(posedge clk) disable iff (rst)
    out_valid && same_process_evicted |-> outcome == cpr_pkg::OUT_REPLACE)
    else $error("eviction flag without a replacement");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("activity right after reset");

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (
  .clk                 (clk),
  .rst                 (rst),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .op                  (op),
  .process_id          (process_id),
  .virtual_page        (virtual_page),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .outcome             (outcome),
  .frame               (frame),
  .same_process_evicted(same_process_evicted)
);

`default_nettype wire

FILE: dv/cpr_checker.sv
module cpr_scoreboard (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       op,
  input  logic [2:0] process_id,
  input  logic [4:0] virtual_page,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] outcome,
  input  logic [1:0] frame,
  input  logic       same_process_evicted,
  output int         errors,
  output int         pending,
  output int         checked,
  output int         hits,
  output int         replaced
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFRAMES = 4;
  localparam int NPAGES  = 32;
  localparam int NPROCS  = 4;

  typedef struct packed {
    logic [1:0] outcome;
    logic [1:0] frame;
    logic       same;
  } page_result_t;

  // shadow copy of the page tables and frame table
  logic       pte_valid   [NPROCS*NPAGES];
  logic [1:0] pte_frame   [NPROCS*NPAGES];
  logic       frm_owned   [NFRAMES];
  logic [2:0] frm_owner   [NFRAMES];
  logic       frm_visited [NFRAMES];
  logic [1:0] hand;

  page_result_t expected_q[$];
  page_result_t want, got, pred;
  int           reported;

  initial begin
    errors   = 0;
    pending  = 0;
    checked  = 0;
    hits     = 0;
    replaced = 0;
    reported = 0;
  end

  task automatic release_frames(input logic [2:0] pid, output page_result_t res);
    for (int f = 0; f < NFRAMES; f++) begin
      if (frm_owned[f] && frm_owner[f] == pid) begin
        frm_owned[f] = 1'b0;
        frm_owner[f] = 3'd0;
      end
    end
    res = '{cpr_pkg::OUT_RELEASED, 2'd0, 1'b0};
  endtask

  task automatic resolve_access(input logic [2:0] pid, input logic [4:0] vpage,
                                output page_result_t res);
    int         base;
    int         slot;
    logic [1:0] cur;
    logic [1:0] pick;
    bit         found;
    base  = (int'(pid) - 1) * NPAGES;
    slot  = base + (int'(vpage) % NPAGES);
    cur   = pte_frame[slot];
    found = 1'b0;
    pick  = 2'd0;
    if (pte_valid[slot] && frm_owned[cur] && frm_owner[cur] == pid) begin
      frm_visited[cur] = 1'b1;
      res = '{cpr_pkg::OUT_HIT, cur, 1'b0};
    end else begin
      for (int f = 0; f < NFRAMES; f++) begin
        if (!found && !frm_owned[f]) begin
          found = 1'b1;
          pick  = 2'(f);
        end
      end
      if (found) begin
        res = '{cpr_pkg::OUT_FREE, pick, 1'b0};
      end else begin
        // second chance: clear visit bits until a cold frame turns up
        while (frm_visited[hand]) begin
          frm_visited[hand] = 1'b0;
          hand = 2'((int'(hand) + 1) % NFRAMES);
        end
        pick = hand;
        res  = '{cpr_pkg::OUT_REPLACE, pick, frm_owner[pick] == pid};
      end
      frm_owned[pick]   = 1'b1;
      frm_owner[pick]   = pid;
      frm_visited[pick] = 1'b1;
      // drop this process's stale mappings onto the reused frame
      for (int p = 0; p < NPAGES; p++) begin
        if (pte_frame[base + p] == pick) pte_valid[base + p] = 1'b0;
      end
      pte_frame[slot] = pick;
      pte_valid[slot] = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NPROCS*NPAGES; i++) begin
        pte_valid[i] = 1'b0;
        pte_frame[i] = 2'd0;
      end
      for (int f = 0; f < NFRAMES; f++) begin
        frm_owned[f]   = 1'b0;
        frm_owner[f]   = 3'd0;
        frm_visited[f] = 1'b0;
      end
      hand = 2'd0;
      expected_q.delete();
    end else begin
      // output side first: a result on this edge always belongs to an older beat
      if (out_valid && out_ready) begin
        got = '{outcome, frame, same_process_evicted};
        if (expected_q.size() == 0) begin
          errors++;
          if (reported < 10) begin
            reported++;
            $display("%0t: unexpected result outcome %0d frame %0d same %0b",
                     $time, got.outcome, got.frame, got.same);
          end
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (got !== want) begin
            errors++;
            if (reported < 10) begin
              reported++;
              $display("%0t: mismatch, got outcome %0d frame %0d same %0b, want %0d %0d %0b",
                       $time, got.outcome, got.frame, got.same,
                       want.outcome, want.frame, want.same);
            end
          end
        end
      end
      if (in_valid && in_ready && process_id != 3'd0 && process_id <= NPROCS) begin
        if (op == cpr_pkg::OP_RELEASE) release_frames(process_id, pred);
        else resolve_access(process_id, virtual_page, pred);
        if (pred.outcome == cpr_pkg::OUT_HIT) hits++;
        if (pred.outcome == cpr_pkg::OUT_REPLACE) replaced++;
        expected_q = {expected_q, pred};
      end
    end
    pending = expected_q.size();
  end

endmodule

FILE: dv/clock_page_replacement_tb.sv
module clock_page_replacement_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKE, RX_ALTERNATE} rx_mode_e;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       in_valid     = 1'b0;
  logic       op           = cpr_pkg::OP_ACCESS;
  logic [2:0] process_id   = 3'd0;
  logic [4:0] virtual_page = 5'd0;
  logic       out_ready    = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [1:0] outcome;
  wire  [1:0] frame;
  wire        same_process_evicted;

  int errors, pending, checked, hits, replaced;
  int n_sent     = 0;
  int burst_left = 0;

  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  clock_page_replacement uut (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .op                   (op),
    .process_id           (process_id),
    .virtual_page         (virtual_page),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .outcome              (outcome),
    .frame                (frame),
    .same_process_evicted (same_process_evicted)
  );

  cpr_scoreboard page_check (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .op                   (op),
    .process_id           (process_id),
    .virtual_page         (virtual_page),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .outcome              (outcome),
    .frame                (frame),
    .same_process_evicted (same_process_evicted),
    .errors               (errors),
    .pending              (pending),
    .checked              (checked),
    .hits                 (hits),
    .replaced             (replaced)
  );

  // receiver: switches between stall patterns at random intervals
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(5, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_CHOKE:  out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= ~out_ready;
    endcase
  end

  // one beat, in bursts with random gaps in between
  task automatic issue(input logic o, input logic [2:0] pid, input logic [4:0] vpage);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid     <= 1'b1;
    op           <= o;
    process_id   <= pid;
    virtual_page <= vpage;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [2:0] cur_pid;
    int         roll;
    int         pick;
    cur_pid = 3'd1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // fill every frame, hit, then force sweeps with same and other process victims
    issue(cpr_pkg::OP_ACCESS,  3'd1, 5'd0);
    issue(cpr_pkg::OP_ACCESS,  3'd1, 5'd1);
    issue(cpr_pkg::OP_ACCESS,  3'd1, 5'd2);
    issue(cpr_pkg::OP_ACCESS,  3'd1, 5'd3);
    issue(cpr_pkg::OP_ACCESS,  3'd1, 5'd0);
    issue(cpr_pkg::OP_ACCESS,  3'd1, 5'd4);
    issue(cpr_pkg::OP_ACCESS,  3'd1, 5'd0);
    issue(cpr_pkg::OP_ACCESS,  3'd2, 5'd31);
    issue(cpr_pkg::OP_ACCESS,  3'd4, 5'd31);
    issue(cpr_pkg::OP_RELEASE, 3'd1, 5'd17);
    issue(cpr_pkg::OP_RELEASE, 3'd3, 5'd31);
    issue(cpr_pkg::OP_ACCESS,  3'd2, 5'd31);
    // stale entry after release must fault
    issue(cpr_pkg::OP_ACCESS,  3'd1, 5'd1);
    // out of range process ids are dropped
    issue(cpr_pkg::OP_ACCESS,  3'd0, 5'd5);
    issue(cpr_pkg::OP_RELEASE, 3'd5, 5'd0);
    issue(cpr_pkg::OP_ACCESS,  3'd7, 5'd31);
    issue(cpr_pkg::OP_ACCESS,  3'd6, 5'd0);
    issue(cpr_pkg::OP_RELEASE, 3'd4, 5'd0);
    issue(cpr_pkg::OP_ACCESS,  3'd4, 5'd31);
    issue(cpr_pkg::OP_ACCESS,  3'd3, 5'd16);
    issue(cpr_pkg::OP_ACCESS,  3'd3, 5'd16);

    // random traffic with locality so hits and sweeps both show up
    repeat (1060) begin
      if ($urandom_range(0, 99) < 20) cur_pid = 3'($urandom_range(1, 4));
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        pick = $urandom_range(0, 3);
        issue(1'($urandom_range(0, 1)), (pick == 0) ? 3'd0 : 3'(4 + pick),
              5'($urandom_range(0, 31)));
      end else if (roll < 10) begin
        issue(cpr_pkg::OP_RELEASE, cur_pid, 5'($urandom_range(0, 31)));
      end else begin
        issue(cpr_pkg::OP_ACCESS, cur_pid,
              ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 5))
                                         : 5'($urandom_range(0, 31)));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("%0d beats offered, %0d results checked", n_sent, checked);
    $display("%0d hits, %0d clock sweep replacements", hits, replaced);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
